// ===== design/tridiagonal_thomas_solver_top_macros.svh =====
// Assertion macros for the tridiagonal solver checker.
// Used by tts_checker.sv; needs clk_i and rst_ni in scope.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_TOP_MACROS_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_TOP_MACROS_SVH

// Clocked assertion, off during reset
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication shorthand on the same clock
`define TTS_ASSERT_IMP(lbl, pre, post, msg) \
  `TTS_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ===== design/tts_pkg.sv =====
// Shared types, constants and helpers of the tridiagonal solver.
// No dependencies; used by the divider, datapath, controller and top level.
`default_nettype none

package tts_pkg;

  localparam int MaxRowsDefault = 64;
  localparam int RowIdxW        = 6;
  localparam int DivSteps       = 34;  // quotient bits below the overflow point
  localparam int QuotW          = 36;  // signed quotient, saturating range included

  // Controller commands to the datapath
  typedef struct packed {
    logic load_in;
    logic rd_fwd;
    logic rd_back;
    logic mul_c;
    logic mul_d;
    logic mul_back;
    logic num_back;
    logic div_fwd;
    logic div_back;
    logic res_ap;
    logic res_dp;
    logic wr_row;
    logic idx_cnt;
    logic idx_cntm1;
    logic out_load;
  } tts_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic row0;
    logic full;
    logic last;
    logic idx0;
    logic div_done;
    logic out_free;
  } tts_status_t;

  // Clamp a 37-bit signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tts_div.sv =====
// Iterative signed divider, 64-bit numerator by 32-bit divisor, one bit a cycle.
// Quotient truncates toward zero, zero divisor gives zero. Uses tts_pkg.
`default_nettype none

module tts_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [63:0]                   num_i,
  input  wire logic signed [31:0]                   den_i,
  output logic                                      done_o,
  output logic signed [tts_pkg::QuotW-1:0]          quot_o
);

  localparam int Steps = tts_pkg::DivSteps;
  localparam int CntW  = $clog2(Steps + 1);

  logic [63:0]            nmag;
  logic [31:0]            dmag;
  logic [32:0]            rem_q;
  logic [Steps-1:0]       sh_q;
  logic [31:0]            dmag_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q, ovf_q, zero_q, neg_q;
  logic [32:0]            trial;
  logic                   fits;

  assign nmag  = num_i[63] ? 64'(-num_i) : 64'(num_i);
  assign dmag  = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign trial = {rem_q[31:0], sh_q[Steps-1]};
  assign fits  = trial >= {1'b0, dmag_q};

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {3'b000, nmag[63:Steps]};
      sh_q   <= nmag[Steps-1:0];
      dmag_q <= dmag;
      ovf_q  <= {2'b00, nmag[63:Steps]} >= dmag;
      zero_q <= den_i == 32'sd0;
      neg_q  <= num_i[63] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dmag_q}) : trial;
      sh_q  <= {sh_q[Steps-2:0], fits};
    end
  end

  // Signed result; overflow stands in as 2^34, which saturates downstream
  always_comb begin
    logic signed [tts_pkg::QuotW-1:0] mag;
    mag = ovf_q ? (tts_pkg::QuotW'(1) <<< Steps) : {2'b00, sh_q};
    if (zero_q) begin
      quot_o = '0;
    end else begin
      quot_o = neg_q ? -mag : mag;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/tts_dp.sv =====
// Datapath of the tridiagonal solver: row store, multiplier, divider, output stage.
// Uses tts_pkg and tts_div; driven by tts_ctrl commands.
`default_nettype none

module tts_dp #(
  parameter int MAX_ROWS = tts_pkg::MaxRowsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tts_pkg::tts_cmd_t             cmd_i,
  output tts_pkg::tts_status_t               sts_o,
  input  wire logic [31:0]                   sub_diag_i,
  input  wire logic [31:0]                   diag_i,
  input  wire logic [31:0]                   super_diag_i,
  input  wire logic [31:0]                   rhs_i,
  input  wire logic                          last_row_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [31:0]                        solution_o,
  output logic [tts_pkg::RowIdxW-1:0]        row_index_o,
  output logic                               last_out_o,
  output logic                               singular_o
);

  localparam int IdxW = $clog2(MAX_ROWS);
  localparam int CntW = $clog2(MAX_ROWS + 1);

  // Row store: {c, d', a'} per row
  logic [95:0]                   mem_q [MAX_ROWS];
  logic [95:0]                   rd_q;
  logic [IdxW-1:0]               rd_addr;

  logic signed [31:0]            b_q, a_q, c_q, d_q, ap_q, dp_q, x_q;
  logic                          last_q;
  logic [CntW-1:0]               cnt_q, cnt_m1;
  logic [IdxW-1:0]               idx_q;
  logic                          zp_q;
  logic signed [63:0]            prod_q, num_q;
  logic signed [31:0]            rd_ap, rd_dp, rd_c, op_x, op_y;
  logic signed [31:0]            store_ap, store_dp;
  logic                          first;
  logic                          div_done;
  logic signed [tts_pkg::QuotW-1:0] quot;
  logic signed [36:0]            quot_x;
  logic [31:0]                   x_sat;
  logic                          out_valid_q;

  assign rd_ap  = rd_q[31:0];
  assign rd_dp  = rd_q[63:32];
  assign rd_c   = rd_q[95:64];
  assign cnt_m1 = cnt_q - CntW'(1);
  assign first  = {1'b0, idx_q} == cnt_m1;
  assign rd_addr = cmd_i.rd_back ? idx_q : cnt_m1[IdxW-1:0];

  // Input row registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      b_q    <= sub_diag_i;
      a_q    <= diag_i;
      c_q    <= super_diag_i;
      d_q    <= rhs_i;
      last_q <= last_row_i;
    end
  end

  // Row store write and registered read
  assign store_ap = (cnt_q == '0) ? a_q : ap_q;
  assign store_dp = (cnt_q == '0) ? d_q : dp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_row) begin
      mem_q[cnt_q[IdxW-1:0]] <= {(last_q ? 32'd0 : c_q), store_dp, store_ap};
    end
    if (cmd_i.rd_fwd || cmd_i.rd_back) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Shared multiplier
  assign op_x = cmd_i.mul_back ? rd_c : b_q;
  assign op_y = cmd_i.mul_back ? x_q : (cmd_i.mul_d ? rd_dp : rd_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_c || cmd_i.mul_d || cmd_i.mul_back) begin
      prod_q <= op_x * op_y;
    end
    // Back numerator: d' * 2^16 minus c * x(i+1)
    if (cmd_i.num_back) begin
      num_q <= {{16{rd_dp[31]}}, rd_dp, 16'd0} - (first ? 64'sd0 : prod_q);
    end
  end

  tts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_fwd || cmd_i.div_back),
    .num_i   (cmd_i.div_back ? num_q : prod_q),
    .den_i   (rd_ap),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign quot_x = {quot[tts_pkg::QuotW-1], quot};
  assign x_sat  = tts_pkg::sat32(quot_x);

  // Forward results
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ap) begin
      ap_q <= tts_pkg::sat32({{5{a_q[31]}}, a_q} - quot_x);
    end
    if (cmd_i.res_dp) begin
      dp_q <= tts_pkg::sat32({{5{d_q[31]}}, d_q} - quot_x);
    end
  end

  // Run control state: row count, back index, zero pivot, last solution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      zp_q  <= 1'b0;
      x_q   <= '0;
    end else begin
      if (cmd_i.wr_row) begin
        cnt_q <= cnt_q + CntW'(1);
        if (store_ap == 32'sd0) begin
          zp_q <= 1'b1;
        end
      end
      if (cmd_i.idx_cnt) begin
        idx_q <= cnt_q[IdxW-1:0];
      end else if (cmd_i.idx_cntm1) begin
        idx_q <= cnt_m1[IdxW-1:0];
      end
      if (cmd_i.out_load) begin
        x_q <= x_sat;
        if (idx_q == '0) begin
          cnt_q <= '0;
          zp_q  <= 1'b0;
        end else begin
          idx_q <= idx_q - IdxW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      solution_o  <= x_sat;
      row_index_o <= tts_pkg::RowIdxW'(idx_q);
      last_out_o  <= idx_q == '0;
      singular_o  <= zp_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.row0     = cnt_q == '0;
  assign sts_o.full     = cnt_q == CntW'(MAX_ROWS);
  assign sts_o.last     = last_q;
  assign sts_o.idx0     = idx_q == '0;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== design/tts_ctrl.sv =====
// Controller of the tridiagonal solver: sequences forward sweep and back substitution.
// Uses tts_pkg command and status types; drives tts_dp.
`default_nettype none

module tts_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire tts_pkg::tts_status_t  sts_i,
  output tts_pkg::tts_cmd_t          cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_FCHK = 14'b00000000000010,
    S_FRD  = 14'b00000000000100,
    S_FMUL = 14'b00000000001000,
    S_FDS  = 14'b00000000010000,
    S_FDIV = 14'b00000000100000,
    S_FRES = 14'b00000001000000,
    S_FWR  = 14'b00000010000000,
    S_BRD  = 14'b00000100000000,
    S_BMUL = 14'b00001000000000,
    S_BNUM = 14'b00010000000000,
    S_BDS  = 14'b00100000000000,
    S_BDIV = 14'b01000000000000,
    S_BOUT = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;  // 0: pivot term, 1: right-side term

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_FCHK;
        end
      end
      S_FCHK: begin
        phase_d = 1'b0;
        if (sts_i.full) begin
          if (sts_i.last) begin
            cmd_o.idx_cntm1 = 1'b1;
            state_d         = S_BRD;
          end else begin
            state_d = S_IDLE;
          end
        end else if (sts_i.row0) begin
          state_d = S_FWR;
        end else begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.rd_fwd = 1'b1;
        state_d      = S_FMUL;
      end
      S_FMUL: begin
        cmd_o.mul_c = !phase_q;
        cmd_o.mul_d = phase_q;
        state_d     = S_FDS;
      end
      S_FDS: begin
        cmd_o.div_fwd = 1'b1;
        state_d       = S_FDIV;
      end
      S_FDIV: begin
        if (sts_i.div_done) begin
          state_d = S_FRES;
        end
      end
      S_FRES: begin
        if (!phase_q) begin
          cmd_o.res_ap = 1'b1;
          phase_d      = 1'b1;
          state_d      = S_FMUL;
        end else begin
          cmd_o.res_dp = 1'b1;
          state_d      = S_FWR;
        end
      end
      S_FWR: begin
        cmd_o.wr_row = 1'b1;
        if (sts_i.last) begin
          cmd_o.idx_cnt = 1'b1;
          state_d       = S_BRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BRD: begin
        cmd_o.rd_back = 1'b1;
        state_d       = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.mul_back = 1'b1;
        state_d        = S_BNUM;
      end
      S_BNUM: begin
        cmd_o.num_back = 1'b1;
        state_d        = S_BDS;
      end
      S_BDS: begin
        cmd_o.div_back = 1'b1;
        state_d        = S_BDIV;
      end
      S_BDIV: begin
        if (sts_i.div_done) begin
          state_d = S_BOUT;
        end
      end
      S_BOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.idx0 ? S_IDLE : S_BRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tridiagonal_thomas_solver_top.sv =====
// Tridiagonal (Thomas) solver, Q16.16. Row 0 is written to the row store directly;
// every later row takes two 34-step divisions in the shared divider.
// After the last row is written, back substitution gives one result per division,
// last row first, and a stalled result holds up the sequence.
// Reset (async, active low) empties the run and clears the output valid flag;
// the row store holds no reset value and is always written before it is read.
`default_nettype none

module tridiagonal_thomas_solver_top #(
  parameter int MAX_ROWS = tts_pkg::MaxRowsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // sub_diag, diag, super_diag, rhs
  input  wire logic         s_axis_tlast,  // last_row
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata,  // solution, row_index, 2 zero bits
  output logic              m_axis_tlast,  // last_out
  output logic              m_axis_tuser   // singular
);

  tts_pkg::tts_cmd_t    cmd;
  tts_pkg::tts_status_t sts;
  logic [31:0]                 solution;
  logic [tts_pkg::RowIdxW-1:0] row_index;

  tts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tts_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sub_diag_i   (s_axis_tdata[31:0]),
    .diag_i       (s_axis_tdata[63:32]),
    .super_diag_i (s_axis_tdata[95:64]),
    .rhs_i        (s_axis_tdata[127:96]),
    .last_row_i   (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .solution_o   (solution),
    .row_index_o  (row_index),
    .last_out_o   (m_axis_tlast),
    .singular_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, row_index, solution};

endmodule

`default_nettype wire

// ===== design/tts_checker.sv =====
// Port-level checker for the tridiagonal solver, bound to the top level.
// Uses the macros of tridiagonal_thomas_solver_top_macros.svh.
`default_nettype none
`include "tridiagonal_thomas_solver_top_macros.svh"

module tts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled result beat stays
  `TTS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  // Its payload stays too
  `TTS_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed")
  // The closing beat of a run is row zero
  `TTS_ASSERT_IMP(a_last_row0, m_axis_tvalid && m_axis_tlast, m_axis_tdata[37:32] == 6'd0, "bad last")
  // No new row is taken while a run is still emitting
  `TTS_ASSERT_IMP(a_no_overlap, m_axis_tvalid && m_axis_tdata[37:32] != 6'd0, !s_axis_tready, "overlap")

endmodule

bind tridiagonal_thomas_solver_top tts_checker u_tts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
